/* src/bta_pkg.sv */
// Shared types and constants of the buddy tree allocator.
package bta_pkg;

    localparam int MAX_LEVEL_DEF = 10;
    localparam int REQ_W         = 16;
    localparam int OFF_W         = 10;
    localparam int LEVELS_W      = 4;
    localparam int LOG_W         = 5;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    localparam logic [LEVELS_W-1:0] TREE_LEVELS_RST = LEVELS_W'(10);

    // Register index of tree_levels (byte address 4 * index)
    localparam logic [ADDR_W-3:0] REG_TREE_LEVELS = '0;

    typedef enum logic [1:0] {
        NS_FREE   = 2'd0,
        NS_TAKEN  = 2'd1,
        NS_HALVED = 2'd2,
        NS_FILLED = 2'd3
    } t_node_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_READ_SIB,
        OP_TAKE,
        OP_DOWN,
        OP_RIGHT,
        OP_BACK,
        OP_MARK_UP,
        OP_FINISH_OK,
        OP_FINISH_FAIL
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   wr_split;
    } t_dp_cmd;

    typedef struct packed {
        t_node_state node;
        logic        at_target;
        logic        idx_odd;
        logic        idx_zero;
        logic        parent_odd;
        logic        too_big;
        logic        clr_last;
        logic        out_free;
    } t_dp_status;

endpackage

/* src/bta_ctrl.sv */
// Sequencer for the tree search, the upward marking and the clearing pass.
module bta_ctrl import bta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL,
        S_BACK,
        S_UP_READ,
        S_UP_EVAL,
        S_DONE,
        S_FAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   taken;

    assign o_in_ready = (r_state == S_IDLE);
    assign taken = (i_status.node == NS_TAKEN) || (i_status.node == NS_FILLED);

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.wr_split = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.too_big ? S_FAIL : S_READ;
            end
            S_READ: begin
                o_cmd.op = OP_READ;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                if (i_status.at_target && (i_status.node == NS_FREE)) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_UP_READ;
                end else if (!i_status.at_target &&
                             ((i_status.node == NS_FREE) ||
                              (i_status.node == NS_HALVED))) begin
                    o_cmd.op       = OP_DOWN;
                    o_cmd.wr_split = (i_status.node == NS_FREE);
                    n_state        = S_READ;
                end else if (i_status.idx_odd) begin
                    o_cmd.op = OP_RIGHT;
                    n_state  = S_READ;
                end else begin
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                if (i_status.idx_zero) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.op = OP_BACK;
                    if (i_status.parent_odd) begin
                        n_state = S_READ;
                    end
                end
            end
            S_UP_READ: begin
                if (i_status.idx_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_READ_SIB;
                    n_state  = S_UP_EVAL;
                end
            end
            S_UP_EVAL: begin
                if (taken) begin
                    o_cmd.op = OP_MARK_UP;
                    n_state  = S_UP_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH_OK;
                    n_state  = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_FINISH_FAIL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/bta_dp.sv */
// Node store, tree walker registers, offset arithmetic and output register.
module bta_dp import bta_pkg::*; #(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [LEVELS_W-1:0] i_tree_levels,
    input  logic [REQ_W-1:0]    i_request_size,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [OFF_W-1:0]    o_block_offset,
    output logic                o_alloc_failed
);

    localparam int IDX_W      = MAX_LEVEL + 1;
    localparam int NODE_COUNT = (2 ** IDX_W) - 1;
    localparam int EXT_W      = (MAX_LEVEL > OFF_W) ? MAX_LEVEL : OFF_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_COUNT - 1);
    localparam logic [LOG_W-1:0] MAX_LV   = LOG_W'(MAX_LEVEL);

    t_node_state r_mem [NODE_COUNT];

    logic [LOG_W-1:0] r_lv;
    logic [LOG_W-1:0] r_tdepth;
    logic             r_big;
    logic [IDX_W-1:0] r_idx;
    logic [LOG_W-1:0] r_depth;
    t_node_state      r_rd_data;
    logic [OFF_W-1:0] r_off;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_out_valid;
    logic [OFF_W-1:0] r_out_off;
    logic             r_out_fail;

    logic [LOG_W-1:0] lv_in;
    logic [LOG_W-1:0] sz_log;
    logic [REQ_W-1:0] req_m1;
    logic [IDX_W-1:0] sib;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] off_full;
    logic [EXT_W-1:0] off_ext;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_node_state      wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             out_free;

    // Saturate the level count to what the store holds
    assign lv_in = (LOG_W'(i_tree_levels) > MAX_LV) ? MAX_LV : LOG_W'(i_tree_levels);

    // ceil(log2(size)), a size of zero counting as one
    always_comb begin
        req_m1 = (i_request_size == '0) ? '0 : i_request_size - REQ_W'(1);
        sz_log = '0;
        for (int i = 0; i < REQ_W; i++) begin
            if (req_m1[i]) begin
                sz_log = LOG_W'(i + 1);
            end
        end
    end

    assign sib    = r_idx[0] ? r_idx + IDX_W'(1) : r_idx - IDX_W'(1);
    assign parent = (r_idx - IDX_W'(1)) >> 1;
    assign child  = {r_idx[IDX_W-2:0], 1'b1};

    // Unit offset: position within the level, scaled by the block length
    assign base     = r_idx + IDX_W'(1) - (IDX_W'(1) << r_depth);
    assign off_full = base << (r_lv - r_depth);
    assign off_ext  = EXT_W'(off_full[MAX_LEVEL-1:0]);

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = NS_FREE;
        re    = 1'b0;
        raddr = r_idx;
        case (i_cmd.op)
            OP_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_idx;
                wdata = NS_FREE;
            end
            OP_TAKE: begin
                we    = 1'b1;
                wdata = NS_TAKEN;
            end
            OP_DOWN: begin
                we    = i_cmd.wr_split;
                wdata = NS_HALVED;
            end
            OP_MARK_UP: begin
                we    = 1'b1;
                waddr = parent;
                wdata = NS_FILLED;
            end
            OP_READ: begin
                re = 1'b1;
            end
            OP_READ_SIB: begin
                re    = 1'b1;
                raddr = sib;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_lv     <= lv_in;
                r_big    <= (sz_log > lv_in);
                r_tdepth <= lv_in - sz_log;
                r_idx    <= '0;
                r_depth  <= '0;
            end
            OP_DOWN: begin
                r_idx   <= child;
                r_depth <= r_depth + LOG_W'(1);
            end
            OP_RIGHT: begin
                r_idx <= r_idx + IDX_W'(1);
            end
            OP_BACK: begin
                r_idx   <= parent[0] ? parent + IDX_W'(1) : parent;
                r_depth <= r_depth - LOG_W'(1);
            end
            OP_MARK_UP: begin
                r_idx <= parent;
            end
            OP_TAKE: begin
                r_off <= off_ext[OFF_W-1:0];
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if ((i_cmd.op == OP_FINISH_OK) || (i_cmd.op == OP_FINISH_FAIL)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FINISH_OK) begin
            r_out_off  <= r_off;
            r_out_fail <= 1'b0;
        end else if (i_cmd.op == OP_FINISH_FAIL) begin
            r_out_off  <= '0;
            r_out_fail <= 1'b1;
        end
    end

    assign o_status.node       = r_rd_data;
    assign o_status.at_target  = (r_depth == r_tdepth);
    assign o_status.idx_odd    = r_idx[0];
    assign o_status.idx_zero   = (r_idx == '0);
    assign o_status.parent_odd = parent[0];
    assign o_status.too_big    = r_big;
    assign o_status.clr_last   = (r_clr_idx == LAST_IDX);
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_block_offset = r_out_off;
    assign o_alloc_failed = r_out_fail;

endmodule

/* src/buddy_tree_allocator_unit.sv */
// Buddy tree allocator: top level with the register port, sequencer and datapath.
//
// Usage
//   Request channel: i_in_valid / o_in_ready carry one word, i_request_size, a
//   block size in units; it is rounded up to a power of two (zero counts as one).
//   Result channel: o_out_valid / i_out_ready carry one word per request,
//   o_block_offset (unit offset of the block) and o_alloc_failed (offset then 0).
//   Register port: tree_levels at byte address 0, pool = 2^tree_levels units,
//   saturated to MAX_LEVEL. Write it only while no request is in flight.
// Sequence
//   Per request: accept, size check, a read and an evaluation per tree node, a step
//   per backtracking move, a read and an evaluation per sibling checked on the way
//   up, a step if the upward pass or a failed search ends at the root, the hand-over.
//   Oversize: no search. One request at a time, by one sequencer, single-port store.
// Reset
//   After reset the node store is swept to unused, one node a cycle, over all
//   2^(MAX_LEVEL+1)-1 nodes (2047 at the default); o_in_ready stays low then.
// Stall
//   The result sits in an output register, so the next request is taken while
//   it waits; a finished request holds until that register is free.
module buddy_tree_allocator_unit import bta_pkg::*; #(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_request_size,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OFF_W-1:0]    o_block_offset,
    output logic                o_alloc_failed,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [LEVELS_W-1:0] r_tree_levels;
    logic                reg_hit;
    t_dp_cmd             cmd;
    t_dp_status          status;

    // Register decode ignores the byte lane bits
    assign reg_hit = (paddr[ADDR_W-1:2] == REG_TREE_LEVELS);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? DATA_W'(r_tree_levels) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_levels <= TREE_LEVELS_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_tree_levels <= pwdata[LEVELS_W-1:0];
        end
    end

    bta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bta_dp #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_tree_levels  (r_tree_levels),
        .i_request_size (i_request_size),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_block_offset (o_block_offset),
        .o_alloc_failed (o_alloc_failed)
    );

endmodule
